[hw/rtl/cmcc_pkg.sv]
package cmcc_pkg;

  localparam int CODE_W = 17;
  localparam int POS_W = 15;
  localparam int LVL_W = 8;

  typedef enum logic [2:0] {
    REPLY_NONE      = 3'd0,
    REPLY_CLOSE_SET = 3'd1,
    REPLY_OPEN_SET  = 3'd2,
    REPLY_UNKNOWN   = 3'd3,
    REPLY_STATUS    = 3'd4
  } reply_t;

  localparam logic [CODE_W-1:0] CMD_CLOSE         = 17'd1000;
  localparam logic [CODE_W-1:0] CMD_OPEN          = 17'd1001;
  localparam logic [CODE_W-1:0] CMD_HEAT0         = 17'd2000;
  localparam logic [CODE_W-1:0] CMD_HEAT50        = 17'd2050;
  localparam logic [CODE_W-1:0] CMD_HEAT100       = 17'd2100;
  localparam logic [CODE_W-1:0] CMD_HEAT150       = 17'd2150;
  localparam logic [CODE_W-1:0] CMD_LIGHT_OFF     = 17'd9999;
  localparam logic [CODE_W-1:0] CMD_CAPTURE_CLOSE = 17'd100000;
  localparam logic [CODE_W-1:0] CMD_CAPTURE_OPEN  = 17'd100001;
  localparam logic [CODE_W-1:0] OPEN_SET_LO       = 17'd40000;
  localparam logic [CODE_W-1:0] OPEN_SET_HI       = 17'd67000;
  localparam logic [CODE_W-1:0] CLOSE_SET_LO      = 17'd10000;
  localparam logic [CODE_W-1:0] CLOSE_SET_HI      = 17'd12055;
  localparam logic [CODE_W-1:0] LIGHT_MIN         = 17'd1;
  localparam logic [CODE_W-1:0] LIGHT_MAX         = 17'd255;

  localparam logic [LVL_W-1:0] HEAT_0   = 8'd0;
  localparam logic [LVL_W-1:0] HEAT_50  = 8'd50;
  localparam logic [LVL_W-1:0] HEAT_100 = 8'd100;
  localparam logic [LVL_W-1:0] HEAT_150 = 8'd150;

  localparam logic [POS_W-1:0] OPEN_RESET  = 15'd27000;
  localparam logic [POS_W-1:0] CLOSE_RESET = 15'd2000;
  localparam logic [POS_W-1:0] POS_RESET   = 15'd2000;

  typedef struct packed {
    reply_t           reply;
    logic             done_res;
    logic [POS_W-1:0] close_limit;
    logic [POS_W-1:0] open_limit;
    logic [POS_W-1:0] position;
    logic [LVL_W-1:0] light_level;
    logic [LVL_W-1:0] heater_power;
  } result_t;

endpackage

[hw/rtl/cover_motor_command_controller_top.sv]
// a result is registered in a two-entry result buffer before the master side sees it
// throughput: one beat per cycle, set by the single-pass decode and move logic,
// while the buffer is not full; it keeps the slave side open while one result waits
// reset: synchronous rst restores limits 27000/2000, position 2000, heater and
// light off, no movement and no pending done, and empties the result buffer
module cover_motor_command_controller_top #(
  parameter int STEP_CENTIDEG = 1500
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // command_code[16:0], zeros
  input  logic [0:0]  s_axis_tuser,   // op[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // done_res, close_limit, open_limit, position,
                                      // light_level, heater_power, zeros
  output logic [2:0]  m_axis_tuser    // reply[2:0]
);
  import cmcc_pkg::*;

  localparam logic signed [POS_W:0] STEP = (POS_W+1)'(STEP_CENTIDEG);

  logic [POS_W-1:0] open_target, open_target_next;
  logic [POS_W-1:0] close_target, close_target_next;
  logic [POS_W-1:0] cover_position, cover_position_next;
  logic [LVL_W-1:0] heater_level, heater_level_next;
  logic [LVL_W-1:0] brightness_level, brightness_level_next;
  logic             opening, opening_next;
  logic             closing, closing_next;
  logic             done_pending, done_pending_next;

  logic             in_acc, out_acc, is_tick;
  logic [CODE_W-1:0] code;
  reply_t           reply;
  result_t          res_new, res0, res1;
  logic [1:0]       cnt;

  logic signed [POS_W:0] open_gap, close_gap;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign is_tick = s_axis_tuser[0];
  assign code    = s_axis_tdata[CODE_W-1:0];

  assign open_gap  = $signed({1'b0, open_target}) - $signed({1'b0, cover_position});
  assign close_gap = $signed({1'b0, cover_position}) - $signed({1'b0, close_target});

  always_comb begin
    open_target_next      = open_target;
    close_target_next     = close_target;
    cover_position_next   = cover_position;
    heater_level_next     = heater_level;
    brightness_level_next = brightness_level;
    opening_next          = opening;
    closing_next          = closing;
    done_pending_next     = done_pending;
    reply                 = REPLY_NONE;
    if (is_tick) begin
      reply             = REPLY_STATUS;
      done_pending_next = 1'b0;
      if (opening) begin
        if (open_gap > STEP) begin
          cover_position_next = cover_position + POS_W'(STEP_CENTIDEG);
        end else begin
          cover_position_next = open_target;
          opening_next        = 1'b0;
          done_pending_next   = 1'b1;
        end
      end else if (closing) begin
        if (close_gap > STEP) begin
          cover_position_next = cover_position - POS_W'(STEP_CENTIDEG);
        end else begin
          cover_position_next = close_target;
          closing_next        = 1'b0;
          done_pending_next   = 1'b1;
        end
      end
    end else begin
      unique case (code)
        CMD_CLOSE: begin
          opening_next = 1'b0;
          closing_next = 1'b1;
        end
        CMD_OPEN: begin
          opening_next = 1'b1;
          closing_next = 1'b0;
        end
        CMD_HEAT0:     heater_level_next = HEAT_0;
        CMD_HEAT50:    heater_level_next = HEAT_50;
        CMD_HEAT100:   heater_level_next = HEAT_100;
        CMD_HEAT150:   heater_level_next = HEAT_150;
        CMD_LIGHT_OFF: brightness_level_next = '0;
        CMD_CAPTURE_CLOSE: begin
          close_target_next = cover_position;
          reply             = REPLY_CLOSE_SET;
        end
        CMD_CAPTURE_OPEN: begin
          open_target_next = cover_position;
          reply            = REPLY_OPEN_SET;
        end
        default: begin
          priority if (code >= OPEN_SET_LO && code <= OPEN_SET_HI) begin
            open_target_next = POS_W'(code - OPEN_SET_LO);
          end else if (code >= CLOSE_SET_LO && code <= CLOSE_SET_HI) begin
            close_target_next = POS_W'(code - CLOSE_SET_LO);
          end else if (code >= LIGHT_MIN && code <= LIGHT_MAX) begin
            brightness_level_next = code[LVL_W-1:0];
          end else begin
            reply = REPLY_UNKNOWN;
          end
        end
      endcase
    end
  end

  // result shows state after a command, position before a tick's move
  always_comb begin
    res_new.reply        = reply;
    res_new.done_res     = is_tick && done_pending;
    res_new.close_limit  = close_target_next;
    res_new.open_limit   = open_target_next;
    res_new.position     = cover_position;
    res_new.light_level  = brightness_level_next;
    res_new.heater_power = heater_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_target      <= OPEN_RESET;
      close_target     <= CLOSE_RESET;
      cover_position   <= POS_RESET;
      heater_level     <= '0;
      brightness_level <= '0;
      opening          <= 1'b0;
      closing          <= 1'b0;
      done_pending     <= 1'b0;
    end else if (in_acc) begin
      open_target      <= open_target_next;
      close_target     <= close_target_next;
      cover_position   <= cover_position_next;
      heater_level     <= heater_level_next;
      brightness_level <= brightness_level_next;
      opening          <= opening_next;
      closing          <= closing_next;
      done_pending     <= done_pending_next;
    end
  end

  // two-entry result buffer, res0 is the head
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (in_acc && !out_acc) begin
      cnt <= cnt + 2'd1;
    end else if (out_acc && !in_acc) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_acc) begin
      if (in_acc && cnt == 2'd1) begin
        res0 <= res_new;
      end else begin
        res0 <= res1;
      end
      if (in_acc && cnt == 2'd2) begin
        res1 <= res_new;
      end
    end else if (in_acc) begin
      if (cnt == 2'd0) begin
        res0 <= res_new;
      end else begin
        res1 <= res_new;
      end
    end
  end

  assign s_axis_tready = (cnt != 2'd2);
  assign m_axis_tvalid = (cnt != 2'd0);
  assign m_axis_tuser  = res0.reply;
  assign m_axis_tdata  = {2'b00, res0.heater_power, res0.light_level, res0.position,
                          res0.open_limit, res0.close_limit, res0.done_res};

  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("result buffer count out of range");

  a_one_direction: assert property (@(posedge clk) disable iff (rst) !(opening && closing))
    else $error("cover moving both ways");

  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    in_acc && cnt == 2'd0 |=> m_axis_tvalid)
    else $error("accepted beat did not produce a result");

endmodule
